// ===== rtl/huffman_stream_decoder_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HUFFMAN_STREAM_DECODER_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/hsd_pkg.sv =====
// Package with the constants and types of the Huffman stream decoder.
package hsd_pkg;
    localparam int MaxNodes   = 1024;
    localparam int StackDepth = 256;
    localparam int NodeW      = $clog2(MaxNodes);
    localparam int CntW       = $clog2(MaxNodes + 1);
    localparam int SpW        = $clog2(StackDepth);
    localparam int LvlW       = $clog2(StackDepth + 1);
    localparam int SlotW      = NodeW + 1;

    typedef enum logic [1:0] {
        ST_SYMBOL = 2'd0,
        ST_END    = 2'd1,
        ST_ERROR  = 2'd2
    } t_status;

    // One entry of the node table.
    typedef struct packed {
        logic [NodeW-1:0] left;
        logic [NodeW-1:0] right;
        logic             is_leaf;
        logic [8:0]       symbol;
    } t_node;
endpackage

// ===== rtl/huffman_stream_decoder.sv =====
// Huffman stream decoder: preorder tree header followed by tree walk decoding.
// A result is held until the next result of its byte or the end of the byte shows whether it is
// last; the last one is registered in S_IDLE, after S_WALK and S_EMIT close the byte.
// One word at a time: a new word is accepted only in S_IDLE, after the last one went through
// S_BIT and S_WALK per bit, S_LINK per linked header node, an extra S_WALK per symbol, stalls.
// Reset: synchronous active low; clears phase, counters and output valid, not the tables.
module huffman_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // symbol[7:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last_of_run
);
    import hsd_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_DECODE, PH_ENDED, PH_ERROR} t_phase;
    typedef enum logic [2:0] {S_IDLE, S_BIT, S_LINK, S_WALK, S_EMIT} t_state;

    t_node            node_mem [MaxNodes];
    logic [SlotW-1:0] stack_mem[StackDepth];

    t_state           r_state;
    t_phase           r_phase;
    logic [7:0]       r_byte;
    logic [3:0]       r_bit_cnt;
    logic [CntW-1:0]  r_nodes_used;
    logic [LvlW-1:0]  r_level;
    logic [3:0]       r_leaf_left;
    logic [7:0]       r_leaf_shift;
    logic [NodeW-1:0] r_walk;
    logic [SlotW-1:0] r_top;       // registered stack read
    t_node            r_rd;        // registered node read
    logic [NodeW-1:0] r_new_idx;   // node to link into popped slot
    logic             r_push_left; // left slot of r_new_idx still to be pushed
    logic             r_out_valid;
    logic [7:0]       r_out_sym;
    t_status          r_out_st;
    logic             r_out_last;
    // pending result of current byte, held until we know whether it is the last
    logic             r_pend;
    logic [7:0]       r_pend_sym;
    t_status          r_pend_st;

    logic             cur_bit;
    logic [SpW-1:0]   top_addr;
    assign cur_bit  = r_byte[7];
    assign top_addr = SpW'(r_level - LvlW'(1));

    assign s_axis_tready = (r_state == S_IDLE) && !(r_pend && r_out_valid);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tlast  = r_out_last;

    // Memory write and read ports.
    logic             nm_we;
    logic [NodeW-1:0] nm_wa;
    t_node            nm_wd;
    logic [NodeW-1:0] nm_ra;
    logic             sm_we;
    logic [SpW-1:0]   sm_wa;
    logic [SlotW-1:0] sm_wd;

    always_ff @(posedge i_clk) begin
        if (nm_we) node_mem[nm_wa] <= nm_wd;
        r_rd <= node_mem[nm_ra];
        if (sm_we) stack_mem[sm_wa] <= sm_wd;
        // The left slot is written in the same cycle as it is read back.
        r_top <= r_push_left ? {r_new_idx, 1'b0} : stack_mem[top_addr];
    end

    // Byte is finished when all bits are used.
    logic bits_done;
    assign bits_done = (r_bit_cnt == 4'd0);

    // A held result cannot move on while the output register is still full.
    logic out_stall;
    assign out_stall = r_out_valid && r_pend && !m_axis_tready;

    // In decoding, the entry of the reached node arrives while in S_WALK.
    logic leaf_hit;
    assign leaf_hit = (r_phase == PH_DECODE) && (r_walk != '0) && r_rd.is_leaf;

    // Header bookkeeping that needs a link: compute popped-slot parent read.
    logic hdr_new_node, hdr_is_leaf_end, link_needed, hdr_fail, push_two;
    always_comb begin
        hdr_new_node    = 1'b0;
        hdr_is_leaf_end = 1'b0;
        hdr_fail        = 1'b0;
        push_two        = 1'b0;
        if (r_leaf_left == 4'd9 && cur_bit) hdr_is_leaf_end = 1'b1;
        if (r_leaf_left == 4'd1) hdr_is_leaf_end = 1'b1;
        if (hdr_is_leaf_end) begin
            hdr_new_node = 1'b1;
            hdr_fail = r_nodes_used >= CntW'(MaxNodes);
        end else if (r_leaf_left == 4'd0) begin
            if (cur_bit) hdr_fail = (r_nodes_used == '0);
            else begin
                hdr_new_node = 1'b1;
                push_two = 1'b1;
                hdr_fail = (r_nodes_used >= CntW'(MaxNodes)) ||
                    ((r_nodes_used != '0) && (r_level >= LvlW'(StackDepth)));
            end
        end
        link_needed = hdr_new_node && !hdr_fail && (r_nodes_used != '0);
    end

    always_comb begin
        nm_we = 1'b0;
        nm_wa = r_new_idx;
        nm_wd = r_rd;
        nm_ra = r_walk;
        sm_we = 1'b0;
        sm_wa = SpW'(r_level);
        sm_wd = '0;
        // The right slot goes in with the new internal node, the left one in the cycle after.
        if (r_push_left) begin
            sm_we = 1'b1;
            sm_wa = top_addr;
            sm_wd = {r_new_idx, 1'b0};
        end
        if (r_state == S_LINK) begin
            nm_we = 1'b1;
            nm_wa = r_top[SlotW-1:1];
            nm_wd = r_rd;
            if (r_top[0]) nm_wd.right = r_new_idx;
            else nm_wd.left = r_new_idx;
        end else if (r_state == S_BIT && r_phase == PH_HEADER) begin
            if (r_leaf_left == 4'd9 && cur_bit) begin
                nm_we = r_nodes_used < CntW'(MaxNodes);
                nm_wa = NodeW'(r_nodes_used);
                nm_wd = '{left: '0, right: '0, is_leaf: 1'b1, symbol: 9'd256};
            end else if (r_leaf_left == 4'd1) begin
                nm_we = r_nodes_used < CntW'(MaxNodes);
                nm_wa = NodeW'(r_nodes_used);
                nm_wd = '{left: '0, right: '0, is_leaf: 1'b1,
                          symbol: {1'b0, r_leaf_shift[6:0], cur_bit}};
            end else if (r_leaf_left == 4'd0 && !cur_bit) begin
                nm_we = r_nodes_used < CntW'(MaxNodes);
                nm_wa = NodeW'(r_nodes_used);
                nm_wd = '{left: '0, right: '0, is_leaf: 1'b0, symbol: 9'd0};
            end
            if (push_two && !hdr_fail) begin
                sm_we = 1'b1;
                sm_wa = SpW'(r_level - LvlW'(link_needed));
                sm_wd = {NodeW'(r_nodes_used), 1'b1};
            end
            // Parent entry for a link is read via the stack top, for S_LINK to write back.
            nm_ra = r_top[SlotW-1:1];
        end else if (r_state == S_BIT && r_phase == PH_DECODE) begin
            nm_ra = cur_bit ? r_rd.right : r_rd.left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_HEADER;
            r_bit_cnt    <= '0;
            r_nodes_used <= '0;
            r_level      <= '0;
            r_leaf_left  <= '0;
            r_leaf_shift <= '0;
            r_walk       <= '0;
            r_push_left  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_push_left <= (r_state == S_BIT) && (r_phase == PH_HEADER) &&
                           push_two && !hdr_fail;
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // Flush a held result as last of its byte.
                    if (r_pend && !r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_sym   <= r_pend_sym;
                        r_out_st    <= r_pend_st;
                        r_out_last  <= 1'b1;
                        r_pend      <= 1'b0;
                    end
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_byte    <= s_axis_tdata;
                        r_bit_cnt <= 4'd8;
                        r_state   <= S_WALK;
                        if (s_axis_tuser) begin
                            r_phase      <= PH_HEADER;
                            r_nodes_used <= '0;
                            r_level      <= '0;
                            r_leaf_left  <= '0;
                            r_leaf_shift <= '0;
                            r_walk       <= '0;
                        end
                    end
                end
                S_WALK: begin
                    // Table and stack reads for the current walk node settle.
                    if (!out_stall) begin
                        if (leaf_hit) begin
                            r_walk     <= '0;
                            r_pend     <= 1'b1;
                            r_pend_sym <= r_rd.symbol[8] ? 8'd0 : r_rd.symbol[7:0];
                            r_pend_st  <= r_rd.symbol[8] ? ST_END : ST_SYMBOL;
                            if (r_rd.symbol[8]) r_phase <= PH_ENDED;
                            if (r_pend) begin
                                r_out_valid <= 1'b1;
                                r_out_sym   <= r_pend_sym;
                                r_out_st    <= r_pend_st;
                                r_out_last  <= 1'b0;
                            end
                        end else if (bits_done || r_phase == PH_ENDED ||
                                     r_phase == PH_ERROR) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_BIT;
                        end
                    end
                end
                S_BIT: begin
                    logic             res;
                    logic [7:0]       rsym;
                    t_status          rst_s;
                    logic [NodeW-1:0] nxt;
                    res = 1'b0; rsym = '0; rst_s = ST_SYMBOL;
                    nxt = cur_bit ? r_rd.right : r_rd.left;
                    r_byte    <= {r_byte[6:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt - 4'd1;
                    r_state   <= S_WALK;
                    if (r_phase == PH_HEADER) begin
                        r_new_idx <= NodeW'(r_nodes_used);
                        if (hdr_fail) begin
                            r_phase <= PH_ERROR;
                            res = 1'b1; rst_s = ST_ERROR;
                        end else if (r_leaf_left == 4'd9 && !cur_bit) begin
                            r_leaf_left  <= 4'd8;
                            r_leaf_shift <= '0;
                        end else if (r_leaf_left > 4'd1 && r_leaf_left != 4'd9) begin
                            r_leaf_left  <= r_leaf_left - 4'd1;
                            r_leaf_shift <= {r_leaf_shift[6:0], cur_bit};
                        end else if (r_leaf_left == 4'd0 && cur_bit) begin
                            r_leaf_left <= 4'd9;
                        end else begin
                            logic [LvlW-1:0] lvl;
                            lvl = r_level;
                            r_nodes_used <= r_nodes_used + CntW'(1);
                            if (link_needed) lvl = lvl - LvlW'(1);
                            if (hdr_is_leaf_end) begin
                                r_leaf_left  <= '0;
                                r_leaf_shift <= '0;
                                if (lvl == '0) begin
                                    r_phase <= PH_DECODE;
                                    r_walk  <= '0;
                                end
                            end
                            if (push_two) lvl = lvl + LvlW'(2);
                            r_level <= lvl;
                            if (link_needed) r_state <= S_LINK;
                        end
                    end else begin
                        r_walk <= nxt;
                    end
                    if (res) begin
                        r_pend     <= 1'b1;
                        r_pend_sym <= rsym;
                        r_pend_st  <= rst_s;
                        if (r_pend) begin
                            r_out_valid <= 1'b1;
                            r_out_sym   <= r_pend_sym;
                            r_out_st    <= r_pend_st;
                            r_out_last  <= 1'b0;
                        end
                    end
                end
                S_LINK: begin
                    // Parent entry read in the previous cycle is written back.
                    r_state <= S_WALK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/hsd_checker.sv =====
// Port-level checker for the Huffman stream decoder, bound to the top level.
`include "huffman_stream_decoder_macros.svh"
module hsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    `HSD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3)
    `HSD_ASSERT_IMP(a_sym_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != 2'd0,
        m_axis_tdata == 8'd0)
    `HSD_ASSERT_IMP(a_end_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != 2'd0,
        m_axis_tlast)
    `HSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `HSD_ASSERT_NEXT(a_in_gap, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (.*);
